@@ sv/sqtd_pkg.sv @@
// Shared types and constants for the square transposition decoder.
package sqtd_pkg;

    // Field widths fixed by the interface
    localparam int BYTE_W    = 8;
    localparam int SIDE_CFG_W = 5;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILLER    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEPARATOR = 2'd2;

    // Configuration reset values
    localparam logic [SIDE_CFG_W-1:0] SIDE_RST      = 5'd16;
    localparam logic [BYTE_W-1:0]     FILLER_RST    = 8'd42;
    localparam logic [BYTE_W-1:0]     SEPARATOR_RST = 8'd32;

    // Row job queue depth
    localparam int Q_DEPTH = 2;

    // Back end sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_CHECK,
        BK_SEP
    } t_back_state;

endpackage

@@ sv/sqtd_grid_mem.sv @@
// Grid store: one write port, one registered read port.
module sqtd_grid_mem
    import sqtd_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [BYTE_W-1:0] i_wr_data,
    input  logic              i_re,
    input  logic [AW-1:0]     i_rd_addr,
    output logic [BYTE_W-1:0] o_rd_data
);

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rd_data;

    // Write incoming bytes
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read on request, hold otherwise
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ sv/sqtd_queue.sv @@
// Short FIFO of row jobs between the front and back ends.
module sqtd_queue
    import sqtd_pkg::*;
#(
    parameter int W = 6
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty,
    output logic         o_full
);

    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNTW = $clog2(Q_DEPTH + 1);

    logic [W-1:0]    r_slot [Q_DEPTH];
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic            push_ok;
    logic            pop_ok;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CNTW'(Q_DEPTH));
    assign o_data  = r_slot[r_rd_ptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    // Advance pointers with wrap
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (push_ok) begin
            n_wr_ptr = (r_wr_ptr == PW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop_ok) begin
            n_rd_ptr = (r_rd_ptr == PW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push_ok && !pop_ok) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop_ok && !push_ok) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    // Store pushed job
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ sv/sqtd_front.sv @@
// Front end: accepts cipher bytes, writes the grid and queues row jobs.
module sqtd_front
    import sqtd_pkg::*;
#(
    parameter int SW = 5,
    parameter int CW = 9,
    parameter int AW = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [BYTE_W-1:0] i_cipher_byte,
    input  logic [SW-1:0]     i_side,
    input  logic [CW-1:0]     i_total,
    input  logic [CW-1:0]     i_first_last,
    input  logic              i_q_full,
    input  logic              i_pending,
    output logic              o_mem_we,
    output logic [AW-1:0]     o_mem_addr,
    output logic [BYTE_W-1:0] o_mem_data,
    output logic              o_push,
    output logic [SW:0]       o_job
);

    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] pos;
    logic [CW-1:0] pos_inc;
    logic [CW-1:0] row_full;
    logic [SW-1:0] row;
    logic          accept;
    logic          is_row_end;

    // Restart the message when the count has run past the grid
    assign pos        = (r_count >= i_total) ? '0 : r_count;
    assign pos_inc    = pos + 1'b1;
    assign is_row_end = (pos >= i_first_last);
    assign row_full   = pos - i_first_last;
    assign row        = row_full[SW-1:0];

    // Stall on a full queue, or on pending runs up to first_last
    assign o_stall = i_q_full || (i_pending && (pos <= i_first_last));
    assign accept  = i_valid && !o_stall;

    // Write the byte at its arrival position
    assign o_mem_we   = accept;
    assign o_mem_addr = pos[AW-1:0];
    assign o_mem_data = i_cipher_byte;

    // Queue a row job for each last-column byte
    assign o_push = accept && is_row_end;
    assign o_job  = {(row == i_side - 1'b1), row};

    always_comb begin
        n_count = r_count;
        if (accept) begin
            n_count = (pos_inc >= i_total) ? '0 : pos_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

@@ sv/sqtd_back.sv @@
// Back end: walks one row down the grid columns and emits its run.
module sqtd_back
    import sqtd_pkg::*;
#(
    parameter int SW = 5,
    parameter int AW = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [SW-1:0]     i_side,
    input  logic [BYTE_W-1:0] i_filler,
    input  logic [BYTE_W-1:0] i_separator,
    input  logic              i_q_empty,
    input  logic [SW:0]       i_job,
    output logic              o_pop,
    output logic              o_busy,
    output logic              o_mem_re,
    output logic [AW-1:0]     o_mem_addr,
    input  logic [BYTE_W-1:0] i_mem_data,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [BYTE_W-1:0] o_plain_byte,
    output logic              o_run_last,
    output logic              o_message_end
);

    t_back_state r_state, n_state;
    logic [SW-1:0]     r_col, n_col;
    logic [AW-1:0]     r_addr, n_addr;
    logic              r_final, n_final;
    logic              r_out_valid, n_out_valid;
    logic [BYTE_W-1:0] r_out_byte, n_out_byte;
    logic              r_out_last, n_out_last;
    logic              r_out_end, n_out_end;
    logic              out_free;
    logic              last_col;

    assign out_free = !r_out_valid || !i_stall;
    assign last_col = (r_col == i_side - 1'b1);

    assign o_busy        = (r_state != BK_IDLE);
    assign o_mem_addr    = r_addr;
    assign o_valid       = r_out_valid;
    assign o_plain_byte  = r_out_byte;
    assign o_run_last    = r_out_last;
    assign o_message_end = r_out_end;

    // Sequence reads and load the output register
    always_comb begin
        n_state     = r_state;
        n_col       = r_col;
        n_addr      = r_addr;
        n_final     = r_final;
        n_out_valid = r_out_valid && i_stall;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        n_out_end   = r_out_end;
        o_pop       = 1'b0;
        o_mem_re    = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (!i_q_empty) begin
                    o_pop   = 1'b1;
                    n_col   = '0;
                    n_addr  = AW'(i_job[SW-1:0]);
                    n_final = i_job[SW];
                    n_state = BK_READ;
                end
            end
            BK_READ: begin
                o_mem_re = 1'b1;
                n_state  = BK_CHECK;
            end
            BK_CHECK: begin
                if (i_mem_data == i_filler || out_free) begin
                    if (i_mem_data != i_filler) begin
                        n_out_valid = 1'b1;
                        n_out_byte  = i_mem_data;
                        n_out_last  = 1'b0;
                        n_out_end   = 1'b0;
                    end
                    if (last_col) begin
                        n_state = BK_SEP;
                    end else begin
                        n_col   = r_col + 1'b1;
                        n_addr  = r_addr + AW'(i_side);
                        n_state = BK_READ;
                    end
                end
            end
            BK_SEP: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = i_separator;
                    n_out_last  = 1'b1;
                    n_out_end   = r_final;
                    n_state     = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_col      <= n_col;
        r_addr     <= n_addr;
        r_final    <= n_final;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
        r_out_end  <= n_out_end;
    end

endmodule

@@ sv/square_transposition_decode.sv @@
// Top level of the square transposition decoder.
// A message of side*side bytes enters one byte per request and is stored in
// a grid RAM at its arrival position; each of the last side bytes releases
// one plaintext row, read down the columns, fillers dropped, closed by the
// separator with run_last set (and message_end on the final row). A byte is
// accepted unless the two-entry row job queue is full, or a row run
// is still pending and the byte is not one of the last column after the
// first; so the first byte of a new message, and the first last-column byte,
// wait until all runs already queued have left the RAM. A row run takes its
// job from the queue, then for each column does one grid RAM read and checks
// its registered data against the filler, and ends with the separator; a
// stalled output holds it on each byte that is not a filler and on the
// separator. The grid RAM has no clearing pass after reset. Write side,
// filler and separator only while the block is idle.
module square_transposition_decode
    import sqtd_pkg::*;
#(
    parameter int MAX_SIDE = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [BYTE_W-1:0]     i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [BYTE_W-1:0]     i_cipher_byte,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [BYTE_W-1:0]     o_plain_byte,
    output logic                  o_run_last,
    output logic                  o_message_end
);

    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int SW    = $clog2(MAX_SIDE + 1);

    logic [SIDE_CFG_W-1:0] r_side;
    logic [BYTE_W-1:0]     r_filler;
    logic [BYTE_W-1:0]     r_separator;
    logic [SW-1:0]         side_eff;
    logic [2*SW-1:0]       side_sq;
    logic [CW-1:0]         total;
    logic [CW-1:0]         first_last;

    logic                  q_push;
    logic                  q_pop;
    logic                  q_empty;
    logic                  q_full;
    logic [SW:0]           q_in;
    logic [SW:0]           q_out;
    logic                  back_busy;
    logic                  pending;

    logic                  mem_we;
    logic [AW-1:0]         mem_wr_addr;
    logic [BYTE_W-1:0]     mem_wr_data;
    logic                  mem_re;
    logic [AW-1:0]         mem_rd_addr;
    logic [BYTE_W-1:0]     mem_rd_data;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side      <= SIDE_RST;
            r_filler    <= FILLER_RST;
            r_separator <= SEPARATOR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SIDE:      r_side      <= i_cfg_data[SIDE_CFG_W-1:0];
                CFG_FILLER:    r_filler    <= i_cfg_data;
                CFG_SEPARATOR: r_separator <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Clamp the side into 1..MAX_SIDE and derive the grid geometry
    always_comb begin
        if (r_side == '0) begin
            side_eff = SW'(1);
        end else if (32'(r_side) > MAX_SIDE) begin
            side_eff = SW'(MAX_SIDE);
        end else begin
            side_eff = SW'(r_side);
        end
    end

    assign side_sq    = side_eff * side_eff;
    assign total      = CW'(side_sq);
    assign first_last = total - CW'(side_eff);
    assign pending    = !q_empty || back_busy;

    sqtd_front #(
        .SW (SW),
        .CW (CW),
        .AW (AW)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_cipher_byte (i_cipher_byte),
        .i_side        (side_eff),
        .i_total       (total),
        .i_first_last  (first_last),
        .i_q_full      (q_full),
        .i_pending     (pending),
        .o_mem_we      (mem_we),
        .o_mem_addr    (mem_wr_addr),
        .o_mem_data    (mem_wr_data),
        .o_push        (q_push),
        .o_job         (q_in)
    );

    sqtd_queue #(
        .W (SW + 1)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    sqtd_grid_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_grid (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_re      (mem_re),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    sqtd_back #(
        .SW (SW),
        .AW (AW)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_side        (side_eff),
        .i_filler      (r_filler),
        .i_separator   (r_separator),
        .i_q_empty     (q_empty),
        .i_job         (q_out),
        .o_pop         (q_pop),
        .o_busy        (back_busy),
        .o_mem_re      (mem_re),
        .o_mem_addr    (mem_rd_addr),
        .i_mem_data    (mem_rd_data),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_plain_byte  (o_plain_byte),
        .o_run_last    (o_run_last),
        .o_message_end (o_message_end)
    );

    // Never push a row job into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && q_full))
        else $error("row job pushed into full queue");

    // The message end mark rides only on a separator
    a_end_on_sep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_message_end) |-> o_run_last)
        else $error("message end without run end");

    // A decoded byte is never the filler
    a_no_filler: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_run_last) |-> (o_plain_byte != r_filler))
        else $error("filler byte emitted");

    // A grid write never hits the address read in the same cycle
    a_no_read_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && mem_re) |-> (mem_wr_addr != mem_rd_addr))
        else $error("grid write hits the row being read");

endmodule
